### rtl/peer_liveness_table_defines.svh
// Assertion macros shared by the peer liveness table RTL.
`ifndef PEER_LIVENESS_TABLE_DEFINES_SVH
`define PEER_LIVENESS_TABLE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("peer liveness table check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("peer liveness table check failed");

`endif

### rtl/plt_pkg.sv
// Shared types, codes and helpers of the peer liveness table.
`timescale 1ns / 1ps
`default_nettype none

package plt_pkg;

  // Input mode codes as they arrive on the stream.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_PING  = 2'd1;
  localparam logic [1:0] MODE_DROP  = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Field widths fixed by the interface.
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned BEAT_W  = 32;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned SLOT_W  = 4;

  // Command queue between front and back.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_PING,
    OP_DROP,
    OP_QUERY
  } op_e;

  typedef enum logic {
    BK_LOOK,
    BK_EXEC
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
  } item_t;

  // Head of the command queue as seen by the back part.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // Map a stream mode code onto an internal operation.
  function automatic op_e mode_to_op(input logic [1:0] mode);
    op_e op;
    case (mode)
      MODE_TICK:  op = OP_TICK;
      MODE_PING:  op = OP_PING;
      MODE_DROP:  op = OP_DROP;
      MODE_QUERY: op = OP_QUERY;
      default:    op = OP_TICK;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

### rtl/peer_liveness_table.sv
// Top level of the peer liveness table.
//
// Input stream: s_axis_tuser carries the mode (tick, ping, drop, query),
// s_axis_tdata the peer IPv4 address. Every input transfer yields exactly
// one result transfer on the m_axis channel: tdata holds alive and slot,
// tuser the status (ok, table full, peer not found).
// The dead limit is written through cfg_we_i / cfg_wdata_i while idle;
// the user is bound to that, as the block itself does not enforce it.
// A two-entry command queue takes input transfers; the back part pops one,
// compares its address with all entries in parallel in that cycle, and
// then, once the result register is free, updates the table and the
// result register. The back part handles one item at a time and pops no
// new item until the current one has been executed.
// Reset clears the beat counter and all valid bits and sets the dead limit
// to 3. When the receiver stalls, the result is held, the back part waits
// with its next item, and input is still taken until the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module peer_liveness_table
  import plt_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,     // dead_limit
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,    // [31:0] peer_addr
  input  wire logic [1:0]  s_axis_tuser,    // [1:0] mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,    // [0] alive, [4:1] slot, [7:5] zero
  output logic [1:0]       m_axis_tuser     // [1:0] status
);

  q_head_t           head;
  logic              pop;
  logic              alive;
  logic [SLOT_W-1:0] slot;

  plt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .mode_i     (s_axis_tuser),
    .addr_i     (s_axis_tdata),
    .pop_i      (pop),
    .head_o     (head)
  );

  plt_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .alive_o     (alive),
    .slot_o      (slot),
    .status_o    (m_axis_tuser)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata = {3'b000, slot, alive};

endmodule

`default_nettype wire

### rtl/plt_front.sv
// Front part: accepts stream transfers, classifies them and queues them.
`timescale 1ns / 1ps
`default_nettype none

module plt_front
  import plt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        mode_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic              pop_i,
  output q_head_t                head_o
);

  `include "peer_liveness_table_defines.svh"

  item_t               q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]  cnt_q, cnt_d;
  logic                push;
  logic                pop;

  // Handshake and queue bookkeeping.
  assign in_ready_o = (cnt_q != Q_CNT_W'(Q_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Classified items go into the queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= '{op: mode_to_op(mode_i), addr: addr_i};
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = q_mem[rd_ptr_q];

  `PLT_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= Q_CNT_W'(Q_DEPTH))

endmodule

`default_nettype wire

### rtl/plt_back.sv
// Back part: table lookup, table update and the result register.
`timescale 1ns / 1ps
`default_nettype none

module plt_back
  import plt_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [LIMIT_W-1:0] cfg_wdata_i,
  input  wire q_head_t            head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    alive_o,
  output logic [SLOT_W-1:0]       slot_o,
  output logic [1:0]              status_o
);

  `include "peer_liveness_table_defines.svh"

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Table storage: valid bits are reset, address and stamp are not.
  logic [ENTRIES-1:0] valid_q;
  logic [ADDR_W-1:0]  addr_q  [ENTRIES];
  logic [BEAT_W-1:0]  stamp_q [ENTRIES];

  logic [BEAT_W-1:0]  beat_q;
  logic [LIMIT_W-1:0] limit_q;

  back_state_e state_q, state_d;

  // Lookup stage results.
  item_t             item_q;
  logic              hit_q;
  logic [IDX_W-1:0]  hit_idx_q;
  logic              free_q;
  logic [IDX_W-1:0]  free_idx_q;

  logic [ENTRIES-1:0] hit_vec;
  logic               hit_any;
  logic [IDX_W-1:0]   hit_idx;
  logic               free_any;
  logic [IDX_W-1:0]   free_idx;

  logic               exec_fire;
  logic               in_exec;
  logic               tick_fire;
  logic [BEAT_W-1:0]  age;
  logic               stale;

  // Result register and its next value.
  logic               out_valid_q;
  logic               alive_q, alive_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [1:0]         status_q, status_d;

  // Parallel compare against every entry, lowest index wins.
  always_comb begin
    hit_vec  = '0;
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      hit_vec[i] = valid_q[i] && (addr_q[i] == head_i.item.addr);
      if (hit_vec[i]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_LOOK: begin
        if (head_i.valid) begin
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (exec_fire) begin
          state_d = BK_LOOK;
        end
      end
      default: state_d = BK_LOOK;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    pop_o     = 1'b0;
    exec_fire = 1'b0;
    case (state_q)
      BK_LOOK: pop_o = head_i.valid;
      BK_EXEC: exec_fire = !out_valid_q || out_ready_i;
      default: begin
        pop_o     = 1'b0;
        exec_fire = 1'b0;
      end
    endcase
  end

  assign in_exec   = (state_q == BK_EXEC);
  assign tick_fire = exec_fire && (item_q.op == OP_TICK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_LOOK;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the item and its lookup outcome.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q     <= head_i.item;
      hit_q      <= hit_any;
      hit_idx_q  <= hit_idx;
      free_q     <= free_any;
      free_idx_q <= free_idx;
    end
  end

  // Age of the matched entry against the dead limit.
  assign age   = beat_q - stamp_q[hit_idx_q];
  assign stale = age > {{(BEAT_W - LIMIT_W){1'b0}}, limit_q};

  // Result payload of the item under execution.
  always_comb begin
    alive_d  = 1'b0;
    slot_d   = '0;
    status_d = ST_OK;
    case (item_q.op)
      OP_PING: begin
        if (hit_q) begin
          slot_d = SLOT_W'(hit_idx_q);
        end else if (free_q) begin
          slot_d = SLOT_W'(free_idx_q);
        end else begin
          status_d = ST_FULL;
        end
      end
      OP_DROP: begin
        if (hit_q) begin
          slot_d = SLOT_W'(hit_idx_q);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      OP_QUERY: begin
        if (hit_q) begin
          slot_d  = SLOT_W'(hit_idx_q);
          alive_d = !stale;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: alive_d = 1'b0;
    endcase
  end

  // Counter, limit, valid bits and the result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= '0;
      limit_q     <= LIMIT_W'(3);
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (exec_fire) begin
        case (item_q.op)
          OP_TICK: beat_q <= beat_q + 1'b1;
          OP_PING: begin
            if (!hit_q && free_q) begin
              valid_q[free_idx_q] <= 1'b1;
            end
          end
          OP_DROP: begin
            if (hit_q) begin
              valid_q[hit_idx_q] <= 1'b0;
            end
          end
          OP_QUERY: begin
            if (hit_q && stale) begin
              valid_q[hit_idx_q] <= 1'b0;
            end
          end
          default: beat_q <= beat_q;
        endcase
      end
    end
  end

  // Entry payload writes and result payload.
  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      alive_q  <= alive_d;
      slot_q   <= slot_d;
      status_q <= status_d;
      if (item_q.op == OP_PING) begin
        if (hit_q) begin
          stamp_q[hit_idx_q] <= beat_q;
        end else if (free_q) begin
          addr_q[free_idx_q]  <= item_q.addr;
          stamp_q[free_idx_q] <= beat_q;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign alive_o     = alive_q;
  assign slot_o      = slot_q;
  assign status_o    = status_q;

  `PLT_ASSERT_NOW(a_hit_unique, clk_i, rst_ni, head_i.valid, $onehot0(hit_vec))
  `PLT_ASSERT_NEXT(a_exec_gives_result, clk_i, rst_ni, exec_fire, out_valid_q)
  `PLT_ASSERT_NEXT(a_exec_waits, clk_i, rst_ni, in_exec && !exec_fire, in_exec)
  `PLT_ASSERT_NEXT(a_tick_counts, clk_i, rst_ni, tick_fire, beat_q == $past(beat_q) + 1'b1)

endmodule

`default_nettype wire

### test/tb_peer_liveness_table.sv
// Self-checking testbench for the peer liveness table: streamed pings, drops, ticks and queries.
`timescale 1ns / 1ps

module tb_peer_liveness_table;
  import plt_pkg::*;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned POOL_SIZE  = 20;
  localparam int unsigned PHASES     = 5;
  localparam int unsigned PHASE_LEN  = 100;
  localparam int unsigned STALL_MAX  = 2000;
  localparam int unsigned DRAIN_WAIT = 8;

  // Expected outcome of one transfer on the result side.
  typedef struct packed {
    logic       alive;
    logic [3:0] slot;
    logic [1:0] status;
  } verdict_t;

  // Tracks the peer table and holds the verdicts that are still owed by the block.
  class liveness_scoreboard;
    logic [31:0] beats;
    logic [15:0] dead_limit;
    logic        used [SLOTS];
    logic [31:0] peer [SLOTS];
    logic [31:0] stamp [SLOTS];
    verdict_t    owed [$];
    int unsigned errors;

    function new();
      beats = '0;
      dead_limit = 16'd3;
      errors = 0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function int find_peer(logic [31:0] addr);
      for (int i = 0; i < SLOTS; i++) begin
        if (used[i] && peer[i] == addr) return i;
      end
      return -1;
    endfunction

    function int find_free();
      for (int i = 0; i < SLOTS; i++) begin
        if (!used[i]) return i;
      end
      return -1;
    endfunction

    // Apply one accepted item to the table and queue the verdict it must produce.
    function void note_input(logic [1:0] mode, logic [31:0] addr);
      verdict_t    v;
      int          s;
      logic [31:0] age;
      v = '0;
      s = find_peer(addr);
      case (mode)
        MODE_TICK: begin
          beats = beats + 32'd1;
        end
        MODE_PING: begin
          if (s < 0) begin
            s = find_free();
            if (s >= 0) begin
              used[s] = 1'b1;
              peer[s] = addr;
            end
          end
          if (s >= 0) begin
            stamp[s] = beats;
            v.slot = s[3:0];
          end else begin
            v.status = ST_FULL;
          end
        end
        MODE_DROP: begin
          if (s >= 0) begin
            used[s] = 1'b0;
            v.slot = s[3:0];
          end else begin
            v.status = ST_NOT_FOUND;
          end
        end
        default: begin
          if (s < 0) begin
            v.status = ST_NOT_FOUND;
          end else begin
            age = beats - stamp[s];
            v.slot = s[3:0];
            // A stale peer is reported dead and removed from the table.
            if (age > {16'd0, dead_limit}) used[s] = 1'b0;
            else v.alive = 1'b1;
          end
        end
      endcase
      owed.push_back(v);
    endfunction

    // Compare one result transfer with the oldest owed verdict.
    function void check_result(logic alive, logic [3:0] slot, logic [1:0] status);
      verdict_t v;
      if (owed.size() == 0) begin
        $error("unexpected result: alive %0d slot %0d status %0d", alive, slot, status);
        errors++;
        return;
      end
      v = owed.pop_front();
      if (alive !== v.alive) begin
        $error("alive: expected %0d, actual %0d", v.alive, alive);
        errors++;
      end
      if (slot !== v.slot) begin
        $error("slot: expected %0d, actual %0d", v.slot, slot);
        errors++;
      end
      if (status !== v.status) begin
        $error("status: expected %0d, actual %0d", v.status, status);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = MODE_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // When set, neither side inserts idle cycles.
  logic        steady = 1'b0;
  int unsigned quiet_cycles = 0;

  liveness_scoreboard sb = new();
  logic [31:0]        addr_pool [POOL_SIZE];

  peer_liveness_table #(
    .ENTRIES(SLOTS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Result side: check every transfer and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata[0], m_axis_tdata[4:1], m_axis_tuser);
    end
    m_axis_tready <= steady || ($urandom_range(99) >= 9);
  end

  // Watchdog: the run is stuck if no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one item, with a random idle gap first, and wait for its transfer.
  task automatic send_item(input logic [1:0] mode, input logic [31:0] addr);
    while (!steady && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= addr;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(mode, addr);
  endtask

  // Stop sending and wait until every owed result has arrived.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_dead_limit(input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.dead_limit = value;
  endtask

  // Mostly known peers so the table fills, refreshes and ages; some random addresses as noise.
  task automatic random_item();
    int unsigned pick;
    logic [1:0]  mode;
    logic [31:0] addr;
    logic [4:0]  pool_idx;
    pick = $urandom_range(99);
    if (pick < 20) mode = MODE_TICK;
    else if (pick < 60) mode = MODE_PING;
    else if (pick < 72) mode = MODE_DROP;
    else mode = MODE_QUERY;
    pool_idx = 5'($urandom_range(POOL_SIZE - 1));
    if ($urandom_range(9) == 0) addr = $urandom;
    else addr = addr_pool[pool_idx];
    send_item(mode, addr);
  endtask

  initial begin
    logic [15:0] limits [PHASES];
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    limits[0] = 16'd0;
    limits[1] = 16'hFFFF;
    limits[2] = 16'd1;
    limits[3] = 16'($urandom_range(2, 8));
    limits[4] = 16'($urandom_range(0, 65535));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part with the reset dead limit of three beats.
    send_item(MODE_QUERY, 32'h0000_0000);  // unknown peer
    send_item(MODE_DROP,  32'hFFFF_FFFF);  // drop of unknown peer
    send_item(MODE_PING,  32'h0000_0000);
    send_item(MODE_PING,  32'hFFFF_FFFF);
    send_item(MODE_PING,  32'h0000_0000);  // refresh
    send_item(MODE_QUERY, 32'hFFFF_FFFF);
    send_item(MODE_TICK,  32'h1234_5678);
    send_item(MODE_TICK,  32'h0000_0000);
    send_item(MODE_TICK,  32'hFFFF_FFFF);
    send_item(MODE_QUERY, 32'h0000_0000);  // age equals the limit, still alive
    send_item(MODE_TICK,  32'h0000_0000);
    send_item(MODE_QUERY, 32'h0000_0000);  // stale, entry is erased
    send_item(MODE_QUERY, 32'h0000_0000);  // gone now
    send_item(MODE_PING,  32'hA5A5_A5A5);  // takes the lowest free slot
    send_item(MODE_DROP,  32'hFFFF_FFFF);
    send_item(MODE_PING,  32'h5A5A_5A5A);
    send_item(MODE_QUERY, 32'hFFFF_FFFF);
    drain();

    // Random phases, each under its own dead limit.
    for (int p = 0; p < PHASES; p++) begin
      write_dead_limit(limits[p]);
      steady <= (p == 2);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (p == 1 && n == PHASE_LEN / 2) drain();
        random_item();
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### peer_liveness_table.f
+incdir+rtl
rtl/plt_pkg.sv
rtl/plt_front.sv
rtl/plt_back.sv
rtl/peer_liveness_table.sv
test/tb_peer_liveness_table.sv
